// File: src/ale_pkg.sv
package ale_pkg;

  // Field widths of the stream payloads.
  localparam int OP_W        = 3;
  localparam int VALUE_W     = 32;
  localparam int POS_W       = 7;
  localparam int STATUS_W    = 2;
  localparam int FOUND_W     = 8;
  localparam int COUNT_W     = 8;
  localparam int IN_TDATA_W  = 48;
  localparam int OUT_TDATA_W = 24;

  // Operation codes.
  localparam logic [OP_W-1:0] OP_ADD_FIRST   = 3'd0;
  localparam logic [OP_W-1:0] OP_ADD_LAST    = 3'd1;
  localparam logic [OP_W-1:0] OP_REMOVE_AT   = 3'd2;
  localparam logic [OP_W-1:0] OP_REMOVE_LAST = 3'd3;
  localparam logic [OP_W-1:0] OP_FIND        = 3'd4;
  localparam logic [OP_W-1:0] OP_SORT        = 3'd5;

  // Status codes.
  localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY  = 2'd2;
  localparam logic [STATUS_W-1:0] ST_BADPOS = 2'd3;

  localparam logic [FOUND_W-1:0] NOT_FOUND = 8'hFF;

  // Write data selection.
  localparam logic [1:0] WD_RDATA = 2'd0;
  localparam logic [1:0] WD_VALUE = 2'd1;
  localparam logic [1:0] WD_CARRY = 2'd2;
  localparam logic [1:0] WD_SORT  = 2'd3;

  // Carry register update.
  localparam logic [1:0] CARRY_HOLD = 2'd0;
  localparam logic [1:0] CARRY_LOAD = 2'd1;
  localparam logic [1:0] CARRY_MIN  = 2'd2;

  typedef struct packed {
    logic                in_load;
    logic                rd_en;
    logic                wr_en;
    logic [1:0]          wd_sel;
    logic [1:0]          carry_sel;
    logic                cnt_inc;
    logic                cnt_dec;
    logic                found_clr;
    logic                found_load;
    logic                res_load;
    logic [STATUS_W-1:0] res_status;
  } cmd_t;

  typedef struct packed {
    logic eq;
    logic gt;
    logic out_busy;
  } sts_t;

endpackage

// File: src/ale_datapath.sv
module ale_datapath #(
  parameter int CAPACITY = 128
) (
  input  logic                           clk,
  input  logic                           rst,
  input  ale_pkg::cmd_t                  cmd,
  output ale_pkg::sts_t                  sts,
  input  logic [$clog2(CAPACITY)-1:0]    rd_addr,
  input  logic [$clog2(CAPACITY)-1:0]    wr_addr,
  input  logic [ale_pkg::VALUE_W-1:0]    in_value,
  output logic [$clog2(CAPACITY+1)-1:0]  count,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [ale_pkg::STATUS_W-1:0]   out_status,
  output logic [ale_pkg::FOUND_W-1:0]    out_found,
  output logic [ale_pkg::COUNT_W-1:0]    out_count
);

  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY+1);

  logic [ale_pkg::VALUE_W-1:0] mem [CAPACITY];
  logic [ale_pkg::VALUE_W-1:0] rdata;
  logic [ale_pkg::VALUE_W-1:0] value_q;
  logic [ale_pkg::VALUE_W-1:0] carry;
  logic [ale_pkg::VALUE_W-1:0] wdata;
  logic [ale_pkg::FOUND_W-1:0] found;
  logic [IDX_W+7:0]            idx_ext;
  logic [CNT_W+7:0]            cnt_ext;

  assign idx_ext = {8'b0, wr_addr};
  assign cnt_ext = {8'b0, count};

  assign sts.eq       = (rdata == value_q);
  assign sts.gt       = ($signed(rdata) > $signed(carry));
  assign sts.out_busy = out_valid && !out_ready;

  always_comb begin
    case (cmd.wd_sel)
      ale_pkg::WD_RDATA: wdata = rdata;
      ale_pkg::WD_VALUE: wdata = value_q;
      ale_pkg::WD_CARRY: wdata = carry;
      ale_pkg::WD_SORT:  wdata = sts.gt ? rdata : carry;
      default:           wdata = rdata;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[wr_addr] <= wdata;
    end
    if (cmd.rd_en) begin
      rdata <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.in_load) begin
      value_q <= in_value;
    end
    case (cmd.carry_sel)
      ale_pkg::CARRY_LOAD: carry <= rdata;
      ale_pkg::CARRY_MIN: begin
        if (!sts.gt) begin
          carry <= rdata;
        end
      end
      default: carry <= carry;
    endcase
    if (cmd.found_clr) begin
      found <= ale_pkg::NOT_FOUND;
    end else if (cmd.found_load) begin
      found <= idx_ext[7:0];
    end
    if (cmd.res_load) begin
      out_status <= cmd.res_status;
      out_found  <= found;
      out_count  <= cnt_ext[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.cnt_inc) begin
        count <= count + CNT_W'(1);
      end else if (cmd.cnt_dec) begin
        count <= count - CNT_W'(1);
      end
      if (cmd.res_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  a_inc_not_full: assert property (@(posedge clk) disable iff (rst)
    cmd.cnt_inc |-> (count < CNT_W'(CAPACITY)) && !cmd.cnt_dec)
    else $error("insert on a full list");

  a_no_clobber: assert property (@(posedge clk) disable iff (rst)
    cmd.res_load |-> !sts.out_busy)
    else $error("result overwritten before its transfer");

  a_rw_apart: assert property (@(posedge clk) disable iff (rst)
    (cmd.rd_en && cmd.wr_en) |-> (rd_addr != wr_addr))
    else $error("read and write hit the same entry");
`endif

endmodule

// File: src/ale_ctrl.sv
module ale_ctrl #(
  parameter int CAPACITY = 128
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [ale_pkg::OP_W-1:0]       op,
  input  logic [ale_pkg::POS_W-1:0]      position,
  input  logic [$clog2(CAPACITY+1)-1:0]  count,
  input  ale_pkg::sts_t                  sts,
  output ale_pkg::cmd_t                  cmd,
  output logic [$clog2(CAPACITY)-1:0]    rd_addr,
  output logic [$clog2(CAPACITY)-1:0]    wr_addr
);

  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY+1);
  localparam int CMP_W = (CNT_W > ale_pkg::POS_W) ? CNT_W : ale_pkg::POS_W;

  localparam logic [3:0] S_IDLE       = 4'd0;
  localparam logic [3:0] S_SHIFT      = 4'd1;
  localparam logic [3:0] S_WRVAL      = 4'd2;
  localparam logic [3:0] S_FIND       = 4'd3;
  localparam logic [3:0] S_SORT_LOAD  = 4'd4;
  localparam logic [3:0] S_SORT_CARRY = 4'd5;
  localparam logic [3:0] S_SORT_RUN   = 4'd6;
  localparam logic [3:0] S_SORT_TAIL  = 4'd7;
  localparam logic [3:0] S_RESULT     = 4'd8;

  logic [3:0]                   state, state_next;
  logic [ale_pkg::STATUS_W-1:0] status_q, status_next;
  logic [IDX_W-1:0]             rd_ptr, rd_ptr_next;
  logic [IDX_W-1:0]             wr_ptr, wr_ptr_next;
  logic [IDX_W-1:0]             pass, pass_next;
  logic [CNT_W-1:0]             left, left_next;
  logic                         pend, pend_next;
  logic                         dir_up, dir_up_next;

  logic [CMP_W-1:0] pos_ext;
  logic [CNT_W-1:0] c_m1;
  logic             full;
  logic             empty;

  assign pos_ext = CMP_W'(position);
  assign c_m1    = count - CNT_W'(1);
  assign full    = (count == CNT_W'(CAPACITY));
  assign empty   = (count == '0);
  assign rd_addr = rd_ptr;
  assign wr_addr = wr_ptr;

  always_comb begin
    cmd            = '0;
    cmd.res_status = status_q;
    in_ready       = (state == S_IDLE);
    state_next     = state;
    status_next    = status_q;
    rd_ptr_next    = rd_ptr;
    wr_ptr_next    = wr_ptr;
    pass_next      = pass;
    left_next      = left;
    pend_next      = 1'b0;
    dir_up_next    = dir_up;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.in_load   = 1'b1;
          cmd.found_clr = 1'b1;
          status_next   = ale_pkg::ST_OK;
          state_next    = S_RESULT;
          case (op)
            ale_pkg::OP_ADD_FIRST: begin
              if (full) begin
                status_next = ale_pkg::ST_FULL;
              end else begin
                rd_ptr_next = c_m1[IDX_W-1:0];
                wr_ptr_next = count[IDX_W-1:0];
                left_next   = count;
                dir_up_next = 1'b0;
                state_next  = empty ? S_WRVAL : S_SHIFT;
              end
            end
            ale_pkg::OP_ADD_LAST: begin
              if (full) begin
                status_next = ale_pkg::ST_FULL;
              end else begin
                wr_ptr_next = count[IDX_W-1:0];
                state_next  = S_WRVAL;
              end
            end
            ale_pkg::OP_REMOVE_AT: begin
              if (empty) begin
                status_next = ale_pkg::ST_EMPTY;
              end else if (pos_ext >= CMP_W'(count)) begin
                status_next = ale_pkg::ST_BADPOS;
              end else begin
                rd_ptr_next = pos_ext[IDX_W-1:0] + IDX_W'(1);
                wr_ptr_next = pos_ext[IDX_W-1:0];
                left_next   = c_m1 - pos_ext[CNT_W-1:0];
                dir_up_next = 1'b1;
                state_next  = S_SHIFT;
              end
            end
            ale_pkg::OP_REMOVE_LAST: begin
              if (empty) begin
                status_next = ale_pkg::ST_EMPTY;
              end else begin
                cmd.cnt_dec = 1'b1;
              end
            end
            ale_pkg::OP_FIND: begin
              if (!empty) begin
                rd_ptr_next = '0;
                wr_ptr_next = '0;
                left_next   = count;
                state_next  = S_FIND;
              end
            end
            ale_pkg::OP_SORT: begin
              if (count >= CNT_W'(2)) begin
                pass_next   = '0;
                rd_ptr_next = c_m1[IDX_W-1:0];
                left_next   = c_m1;
                state_next  = S_SORT_LOAD;
              end
            end
            default: state_next = S_RESULT;
          endcase
        end
      end
      S_SHIFT: begin
        if (left != '0) begin
          cmd.rd_en   = 1'b1;
          rd_ptr_next = dir_up ? rd_ptr + IDX_W'(1) : rd_ptr - IDX_W'(1);
          left_next   = left - CNT_W'(1);
          pend_next   = 1'b1;
        end
        if (pend) begin
          cmd.wr_en   = 1'b1;
          cmd.wd_sel  = ale_pkg::WD_RDATA;
          wr_ptr_next = dir_up ? wr_ptr + IDX_W'(1) : wr_ptr - IDX_W'(1);
        end
        if ((left == '0) && !pend) begin
          if (dir_up) begin
            cmd.cnt_dec = 1'b1;
            state_next  = S_RESULT;
          end else begin
            state_next = S_WRVAL;
          end
        end
      end
      S_WRVAL: begin
        cmd.wr_en   = 1'b1;
        cmd.wd_sel  = ale_pkg::WD_VALUE;
        cmd.cnt_inc = 1'b1;
        state_next  = S_RESULT;
      end
      S_FIND: begin
        if (pend && sts.eq) begin
          cmd.found_load = 1'b1;
          state_next     = S_RESULT;
        end else begin
          if (left != '0) begin
            cmd.rd_en   = 1'b1;
            rd_ptr_next = rd_ptr + IDX_W'(1);
            left_next   = left - CNT_W'(1);
            pend_next   = 1'b1;
          end
          if (pend) begin
            wr_ptr_next = wr_ptr + IDX_W'(1);
          end
          if ((left == '0) && !pend) begin
            state_next = S_RESULT;
          end
        end
      end
      S_SORT_LOAD: begin
        cmd.rd_en   = 1'b1;
        rd_ptr_next = rd_ptr - IDX_W'(1);
        state_next  = S_SORT_CARRY;
      end
      S_SORT_CARRY: begin
        cmd.carry_sel = ale_pkg::CARRY_LOAD;
        cmd.rd_en     = 1'b1;
        rd_ptr_next   = rd_ptr - IDX_W'(1);
        left_next     = left - CNT_W'(1);
        wr_ptr_next   = c_m1[IDX_W-1:0];
        state_next    = S_SORT_RUN;
      end
      S_SORT_RUN: begin
        cmd.wr_en     = 1'b1;
        cmd.wd_sel    = ale_pkg::WD_SORT;
        cmd.carry_sel = ale_pkg::CARRY_MIN;
        wr_ptr_next   = wr_ptr - IDX_W'(1);
        if (left != '0) begin
          cmd.rd_en   = 1'b1;
          rd_ptr_next = rd_ptr - IDX_W'(1);
          left_next   = left - CNT_W'(1);
        end else begin
          state_next = S_SORT_TAIL;
        end
      end
      S_SORT_TAIL: begin
        cmd.wr_en  = 1'b1;
        cmd.wd_sel = ale_pkg::WD_CARRY;
        if ((CNT_W'(pass) + CNT_W'(2)) < count) begin
          pass_next   = pass + IDX_W'(1);
          rd_ptr_next = c_m1[IDX_W-1:0];
          left_next   = c_m1 - CNT_W'(1) - CNT_W'(pass);
          state_next  = S_SORT_LOAD;
        end else begin
          state_next = S_RESULT;
        end
      end
      S_RESULT: begin
        if (!sts.out_busy) begin
          cmd.res_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      pend  <= 1'b0;
    end else begin
      state <= state_next;
      pend  <= pend_next;
    end
  end

  always_ff @(posedge clk) begin
    status_q <= status_next;
    rd_ptr   <= rd_ptr_next;
    wr_ptr   <= wr_ptr_next;
    pass     <= pass_next;
    left     <= left_next;
    dir_up   <= dir_up_next;
  end

endmodule

// File: src/array_list_engine_core.sv
// Each transfer is taken in the idle state. Remove_last, rejected operations, unused codes, find
// on an empty list and sort of under two entries go from there straight to the result state;
// add_last writes the value, add_first shifts every entry up and then writes it, remove_at shifts
// the entries after its position down, find walks the list up to its first match and sort runs
// its passes. The next transfer is taken in the cycle after the result loads, later if the
// previous result still waits. Reset (rst, synchronous) empties the list.
module array_list_engine_core #(
  parameter int CAPACITY = 128
) (
  input  logic                               clk,
  input  logic                               rst,
  // Input stream. s_tdata fields from bit 0: op[2:0], value[34:3], position[41:35],
  // zero padding[47:42].
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [ale_pkg::IN_TDATA_W-1:0]     s_tdata,
  // Result stream. m_tdata fields from bit 0: status[1:0], found_index[9:2], count[17:10],
  // zero padding[23:18].
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [ale_pkg::OUT_TDATA_W-1:0]    m_tdata
);

  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY+1);

  // Input field offsets within s_tdata.
  localparam int VALUE_LSB = ale_pkg::OP_W;
  localparam int POS_LSB   = VALUE_LSB + ale_pkg::VALUE_W;
  localparam int OUT_USED  = ale_pkg::STATUS_W + ale_pkg::FOUND_W + ale_pkg::COUNT_W;

  ale_pkg::cmd_t                cmd;
  ale_pkg::sts_t                sts;
  logic [IDX_W-1:0]             rd_addr;
  logic [IDX_W-1:0]             wr_addr;
  logic [CNT_W-1:0]             count;
  logic [ale_pkg::OP_W-1:0]     op;
  logic [ale_pkg::VALUE_W-1:0]  value;
  logic [ale_pkg::POS_W-1:0]    position;
  logic [ale_pkg::STATUS_W-1:0] status;
  logic [ale_pkg::FOUND_W-1:0]  found_index;
  logic [ale_pkg::COUNT_W-1:0]  out_count;

  assign op       = s_tdata[ale_pkg::OP_W-1:0];
  assign value    = s_tdata[VALUE_LSB +: ale_pkg::VALUE_W];
  assign position = s_tdata[POS_LSB +: ale_pkg::POS_W];

  // The controller sequences each operation over the entry memory: shifts copy one entry a
  // cycle through the registered read port, find compares one entry a cycle, and sort runs
  // bubble passes that carry the smallest value seen so far down toward the front of the list.
  ale_ctrl #(
    .CAPACITY (CAPACITY)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .op       (op),
    .position (position),
    .count    (count),
    .sts      (sts),
    .cmd      (cmd),
    .rd_addr  (rd_addr),
    .wr_addr  (wr_addr)
  );

  // The datapath holds the entry memory, the entry count, the compare logic and the result
  // register, which lets a finished result wait while the next transfer is taken in.
  ale_datapath #(
    .CAPACITY (CAPACITY)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .sts        (sts),
    .rd_addr    (rd_addr),
    .wr_addr    (wr_addr),
    .in_value   (value),
    .count      (count),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_status (status),
    .out_found  (found_index),
    .out_count  (out_count)
  );

  assign m_tdata = {{(ale_pkg::OUT_TDATA_W - OUT_USED){1'b0}}, out_count, found_index, status};

endmodule

// File: verif/ale_list_scoreboard_pkg.sv
package ale_list_scoreboard_pkg;

  import ale_pkg::*;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [FOUND_W-1:0]  found;
    logic [COUNT_W-1:0]  count;
  } list_result_t;

  // Mirrors the list contents and queues the result each accepted operation must produce.
  class list_scoreboard;
    int           held_entries[$];
    list_result_t pending_results[$];
    int           capacity;
    int           errors;
    int           checked;
    int           peak_count;
    int           op_tally[8];
    int           status_tally[4];

    function new(int cap);
      capacity   = cap;
      errors     = 0;
      checked    = 0;
      peak_count = 0;
      foreach (op_tally[k]) op_tally[k] = 0;
      foreach (status_tally[k]) status_tally[k] = 0;
    endfunction

    function int held();
      return held_entries.size();
    endfunction

    function int pending();
      return pending_results.size();
    endfunction

    function int pick_entry();
      return held_entries[$urandom_range(0, held_entries.size() - 1)];
    endfunction

    // Applies one accepted operation to the mirrored list.
    function void note_input(logic [OP_W-1:0] op, logic [VALUE_W-1:0] value,
                             logic [POS_W-1:0] pos);
      list_result_t r;
      int           v;
      int           i;
      int           j;
      int           t;
      r.status = ST_OK;
      r.found  = NOT_FOUND;
      v        = value;
      case (op)
        OP_ADD_FIRST: begin
          if (held_entries.size() >= capacity) r.status = ST_FULL;
          else held_entries.push_front(v);
        end
        OP_ADD_LAST: begin
          if (held_entries.size() >= capacity) r.status = ST_FULL;
          else held_entries.push_back(v);
        end
        OP_REMOVE_AT: begin
          if (held_entries.size() == 0) r.status = ST_EMPTY;
          else if (pos >= held_entries.size()) r.status = ST_BADPOS;
          else held_entries.delete(pos);
        end
        OP_REMOVE_LAST: begin
          if (held_entries.size() == 0) r.status = ST_EMPTY;
          else void'(held_entries.pop_back());
        end
        OP_FIND: begin
          for (i = 0; i < held_entries.size(); i++) begin
            if (held_entries[i] == v) begin
              r.found = FOUND_W'(i);
              break;
            end
          end
        end
        OP_SORT: begin
          // Ascending signed order; equal entries are interchangeable.
          for (i = 1; i < held_entries.size(); i++) begin
            t = held_entries[i];
            j = i - 1;
            while (j >= 0 && held_entries[j] > t) begin
              held_entries[j + 1] = held_entries[j];
              j--;
            end
            held_entries[j + 1] = t;
          end
        end
        default: ;
      endcase
      r.count = COUNT_W'(held_entries.size());
      if (held_entries.size() > peak_count) peak_count = held_entries.size();
      op_tally[op]++;
      status_tally[r.status]++;
      pending_results.push_back(r);
    endfunction

    // Compares one accepted result with the oldest pending expectation.
    function void check_result(logic [OUT_TDATA_W-1:0] data);
      list_result_t got;
      list_result_t want;
      got.status = data[1:0];
      got.found  = data[9:2];
      got.count  = data[17:10];
      checked++;
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result: status %0d found %0d count %0d", $time,
                 got.status, $signed(got.found), got.count);
        return;
      end
      want = pending_results.pop_front();
      if (got.status != want.status) begin
        errors++;
        $display("%0t: status mismatch, expected %0d, got %0d", $time, want.status,
                 got.status);
      end
      if (got.found != want.found) begin
        errors++;
        $display("%0t: found_index mismatch, expected %0d, got %0d", $time,
                 $signed(want.found), $signed(got.found));
      end
      if (got.count != want.count) begin
        errors++;
        $display("%0t: count mismatch, expected %0d, got %0d", $time, want.count,
                 got.count);
      end
    endfunction
  endclass

endpackage

// File: verif/array_list_engine_core_test.sv
module array_list_engine_core_test;

  timeunit 1ns;
  timeprecision 1ps;

  import ale_pkg::*;
  import ale_list_scoreboard_pkg::*;

  localparam int CAPACITY    = 128;
  // The slowest correct run stays well below this, full-list sorts included; every other
  // operation costs at most a list walk plus the idle gaps.
  localparam int CYCLE_LIMIT = 400000;
  localparam int LONG_HOLD   = 400;
  localparam int PAD_W       = IN_TDATA_W - OP_W - VALUE_W - POS_W;

  // Operation codes the block does not define; they must change nothing.
  localparam logic [OP_W-1:0] OP_SPARE_LO = 3'd6;
  localparam logic [OP_W-1:0] OP_SPARE_HI = 3'd7;

  localparam logic [VALUE_W-1:0] VAL_MIN = 32'h8000_0000;
  localparam logic [VALUE_W-1:0] VAL_MAX = 32'h7FFF_FFFF;
  localparam logic [VALUE_W-1:0] VAL_NEG = 32'hFFFF_FFFF;

  logic                   clk      = 1'b0;
  logic                   rst      = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata  = '0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;

  list_scoreboard board;

  // Percentage of transfers followed by an idle gap, per side; zero gives a stretch without
  // any idling.
  int send_idle_pct = 20;
  int recv_idle_pct = 20;
  // Set by the stimulus to make the receiver hold off for a long stretch.
  bit hold_request  = 1'b0;
  int cycle_count   = 0;

  array_list_engine_core #(
    .CAPACITY(CAPACITY)
  ) uut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Watchdog: a hung handshake or a runaway operation ends the run here.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles with %0d results outstanding", cycle_count,
               board.pending());
      $display("simulation failed");
      $finish;
    end
  end

  // A gap is drawn only for the given percentage of calls; about one in ten of those is long.
  function automatic int pick_gap(int pct);
    if ($urandom_range(0, 99) >= pct) return 0;
    if ($urandom_range(0, 9) == 0) return $urandom_range(10, 40);
    return $urandom_range(1, 3);
  endfunction

  // Values lean toward the extremes and a narrow band around zero, so that duplicates show
  // up for find and sort, while the rest covers every bit of the field.
  function automatic logic [VALUE_W-1:0] pick_value();
    case ($urandom_range(0, 5))
      0: begin
        case ($urandom_range(0, 3))
          0: return VAL_MIN;
          1: return VAL_MAX;
          2: return VAL_NEG;
          default: return '0;
        endcase
      end
      1: return VALUE_W'($urandom_range(0, 16)) - VALUE_W'(8);
      default: return $urandom();
    endcase
  endfunction

  // Offers one operation and holds it until the block takes the transfer. All drives are
  // nonblocking at the rising edge; s_tready is sampled as it stood at that edge.
  task automatic send_op(input logic [OP_W-1:0] op, input logic [VALUE_W-1:0] value,
                         input logic [POS_W-1:0] pos);
    int gap;
    s_tdata  <= {{PAD_W{1'b0}}, pos, value, op};
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
    board.note_input(op, value, pos);
    gap = pick_gap(send_idle_pct);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Pauses the sender until every outstanding result has been transferred.
  task automatic drain_results();
    while (board.pending() != 0) @(posedge clk);
  endtask

  // One random operation on a list kept near the given size. Removal positions are mostly
  // valid, with a share drawn over the whole field to hit the out-of-range case.
  task automatic random_step(input int target);
    int                  n;
    int                  r;
    logic [VALUE_W-1:0]  v;
    logic [POS_W-1:0]    p;
    logic [OP_W-1:0]     op;
    n  = board.held();
    r  = $urandom_range(0, 99);
    v  = pick_value();
    p  = POS_W'($urandom());
    if (r < 16) op = OP_ADD_FIRST;
    else if (r < 32) op = OP_ADD_LAST;
    else if (r < 48) op = OP_REMOVE_AT;
    else if (r < 58) op = OP_REMOVE_LAST;
    else if (r < 78) op = OP_FIND;
    else if (r < 90) op = OP_SORT;
    else if (r < 93) op = $urandom_range(0, 1) ? OP_SPARE_LO : OP_SPARE_HI;
    else op = OP_ADD_LAST;
    if ((op == OP_ADD_FIRST || op == OP_ADD_LAST) && n >= target) op = OP_REMOVE_AT;
    if (op == OP_REMOVE_AT && n > 0 && $urandom_range(0, 3) != 0)
      p = POS_W'($urandom_range(0, n - 1));
    if (op == OP_FIND && n > 0 && $urandom_range(0, 1) == 0) v = board.pick_entry();
    send_op(op, v, p);
  endtask

  // Receiver: checks every result transfer and drives m_tready with random stalls, plus
  // one long hold-off on request so that the block backs up into its input.
  initial begin
    int stall_left;
    int gap;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (!rst && m_tvalid && m_tready) board.check_result(m_tdata);
      if (stall_left > 0) begin
        stall_left--;
        m_tready <= 1'b0;
      end else if (hold_request) begin
        hold_request = 1'b0;
        stall_left   = LONG_HOLD - 1;
        m_tready <= 1'b0;
      end else begin
        gap = pick_gap(recv_idle_pct);
        if (gap > 0) begin
          stall_left = gap - 1;
          m_tready <= 1'b0;
        end else begin
          m_tready <= 1'b1;
        end
      end
    end
  end

  initial begin
    int target;
    int n;
    int r;
    board = new(CAPACITY);
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Directed part: every removal on an empty list (empty must win over a bad position),
    // find and sort on an empty list, the unused codes, extreme values, sort of a single
    // entry, first-match search with duplicates, and removal at both ends and the middle.
    send_op(OP_REMOVE_LAST, '0, '0);
    send_op(OP_REMOVE_AT, '0, 7'd127);
    send_op(OP_REMOVE_AT, '0, 7'd0);
    send_op(OP_FIND, '0, '0);
    send_op(OP_SORT, '0, '0);
    send_op(OP_SPARE_LO, VAL_NEG, 7'd127);
    send_op(OP_ADD_LAST, VAL_MAX, '0);
    send_op(OP_SORT, '0, '0);
    send_op(OP_ADD_FIRST, VAL_MIN, 7'd127);
    send_op(OP_ADD_LAST, '0, '0);
    send_op(OP_ADD_LAST, VAL_NEG, '0);
    send_op(OP_ADD_FIRST, 32'd1, '0);
    send_op(OP_FIND, VAL_MIN, '0);
    send_op(OP_FIND, '0, '0);
    send_op(OP_FIND, 32'd5, '0);
    send_op(OP_REMOVE_AT, '0, 7'd5);
    send_op(OP_REMOVE_AT, '0, 7'd127);
    send_op(OP_ADD_LAST, VAL_MAX, '0);
    send_op(OP_FIND, VAL_MAX, '0);
    send_op(OP_SORT, '0, '0);
    send_op(OP_FIND, VAL_NEG, '0);
    send_op(OP_REMOVE_AT, '0, 7'd0);
    send_op(OP_REMOVE_AT, '0, 7'd4);
    send_op(OP_REMOVE_LAST, '0, '0);
    send_op(OP_REMOVE_AT, '0, 7'd1);
    send_op(OP_SPARE_HI, VAL_MIN, 7'd64);

    // Random operations on short lists, first with idling on both sides, then without.
    send_idle_pct = 30;
    recv_idle_pct = 30;
    for (int k = 0; k < 120; k++) begin
      if (k % 30 == 0) target = $urandom_range(4, 16);
      if (k == 80) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      random_step(target);
    end

    // Back-pressure: the receiver holds off while the sender keeps offering transfers, so
    // the block fills up and drops s_tready. Afterwards the sender waits for the backlog.
    hold_request = 1'b1;
    for (int k = 0; k < 15; k++)
      send_op($urandom_range(0, 1) ? OP_ADD_LAST : OP_FIND, pick_value(), POS_W'($urandom()));
    s_tvalid <= 1'b0;
    drain_results();

    // Fill the list to capacity, try to overflow it at both ends, search the full list,
    // sort it once, then shrink it to six entries mostly through removals.
    send_idle_pct = 20;
    recv_idle_pct = 20;
    while (board.held() < CAPACITY)
      send_op($urandom_range(0, 3) == 0 ? OP_ADD_FIRST : OP_ADD_LAST, pick_value(),
              POS_W'($urandom()));
    send_op(OP_ADD_FIRST, pick_value(), '0);
    send_op(OP_ADD_LAST, pick_value(), 7'd127);
    send_op(OP_FIND, board.held_entries[CAPACITY - 1], '0);
    send_op(OP_FIND, 32'h1234_5679, '0);
    send_op(OP_REMOVE_AT, '0, 7'd127);
    send_op(OP_ADD_LAST, 32'h5A5A_A5A5, '0);
    send_op(OP_FIND, 32'h5A5A_A5A5, '0);
    send_op(OP_SORT, '0, '0);
    while (board.held() > 6) begin
      n = board.held();
      r = $urandom_range(0, 99);
      if (r < 45) send_op(OP_REMOVE_LAST, pick_value(), POS_W'($urandom()));
      else if (r < 85) send_op(OP_REMOVE_AT, pick_value(), POS_W'($urandom_range(0, n - 1)));
      else if (r < 92) send_op(OP_FIND, board.pick_entry(), '0);
      else send_op(OP_ADD_FIRST, pick_value(), '0);
    end

    // A last stretch of short-list traffic.
    target = $urandom_range(2, 10);
    for (int k = 0; k < 40; k++) random_step(target);

    // Wind down: wait for every result, then watch a while for stray transfers.
    s_tvalid <= 1'b0;
    drain_results();
    repeat (50) @(posedge clk);

    $write("Checked %0d results: add_first %0d, add_last %0d, remove_at %0d, ",
           board.checked, board.op_tally[OP_ADD_FIRST], board.op_tally[OP_ADD_LAST],
           board.op_tally[OP_REMOVE_AT]);
    $display("remove_last %0d, find %0d, sort %0d, unused codes %0d.",
             board.op_tally[OP_REMOVE_LAST], board.op_tally[OP_FIND],
             board.op_tally[OP_SORT],
             board.op_tally[OP_SPARE_LO] + board.op_tally[OP_SPARE_HI]);
    $display("Status ok %0d, full %0d, empty %0d, bad position %0d; longest list %0d entries.",
             board.status_tally[ST_OK], board.status_tally[ST_FULL],
             board.status_tally[ST_EMPTY], board.status_tally[ST_BADPOS], board.peak_count);
    if (board.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
